// ===== rtl/rte_pkg.sv =====
package rte_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_DEL    = 2'd2
  } req_e_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        direct;
    logic [31:0] gateway;
    logic [3:0]  out_if;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Clamp a prefix length to 32
  function automatic logic [5:0] len_sat(input logic [5:0] len);
    len_sat = (len > 6'd32) ? 6'd32 : len;
  endfunction

  // Network mask for a length of 0..32
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    len_mask = ~(32'hFFFF_FFFF >> len);
  endfunction

endpackage

// ===== rtl/ipv4_route_table_lpm_unit.sv =====
// IPv4 longest-prefix-match route table with TABLE_DEPTH slots. Each request
// (lookup, add, delete) produces exactly one result. The route entries live
// in a single-port-read RAM; every request walks all slots one per cycle: the
// request is accepted, each slot is compared as its registered RAM read
// returns, and a resolve step writes back and loads the output register,
// waiting while an earlier result is still untaken on the output. A new
// request is taken only while the unit is idle; a finished result may still
// be waiting on the output while the next request is being scanned. Valid
// bits sit in flip-flops and clear at reset, so no clearing pass is needed.
module ipv4_route_table_lpm_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] ip_addr,
  input  logic [5:0]  prefix_len,
  input  logic        has_next_hop,
  input  logic [31:0] gateway_ip,
  input  logic [3:0]  out_if_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        route_is_direct,
  output logic [31:0] route_gateway,
  output logic [3:0]  route_out_if,
  output logic [5:0]  matched_len
);

  import rte_pkg::*;

  state_t state, state_next;

  // Request registers
  logic [1:0]  req;
  logic [31:0] addr;
  logic [31:0] prefix;
  logic [5:0]  len;
  logic        direct;
  logic [31:0] gw;
  logic [3:0]  oif;

  // Scan control
  logic [IDX_W-1:0] scan_idx;
  logic             issue_done;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;

  // Scan results
  logic             best_hit;
  logic [5:0]       best_len;
  entry_t           best_ent;
  logic             dflt_hit;
  entry_t           dflt_ent;
  logic             exact_hit;
  logic             exact_same;
  logic [IDX_W-1:0] exact_idx;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;

  logic [TABLE_DEPTH-1:0] entry_valid;

  logic               accept;
  logic               resolve_go;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_ent;
  entry_t             wr_ent;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic               set_valid;
  logic               clr_valid;
  status_t            res_status;
  entry_t             res_ent;
  logic               chk_live;
  logic [5:0]         sat_len;

  assign rd_ent   = rd_data;
  assign chk_live = chk_vld && entry_valid[chk_idx];
  assign sat_len  = len_sat(prefix_len);
  assign wr_ent   = '{prefix: prefix, len: len, direct: direct, gateway: gw, out_if: oif};

  rte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    resolve_go = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_vld && chk_idx == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!out_valid || out_ready) begin
          resolve_go = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Latch the request, masking and saturating on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= req_type;
      addr   <= ip_addr;
      len    <= sat_len;
      prefix <= ip_addr & len_mask(sat_len);
      direct <= !has_next_hop;
      gw     <= has_next_hop ? gateway_ip : 32'd0;
      oif    <= has_next_hop ? out_if_index : 4'd0;
    end
  end

  // Issue one RAM read per cycle; track the slot whose data returns next
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      issue_done <= 1'b0;
      chk_vld    <= 1'b0;
      chk_idx    <= '0;
    end else if (accept) begin
      scan_idx   <= IDX_W'(1);
      issue_done <= (TABLE_DEPTH == 1);
      chk_vld    <= 1'b1;
      chk_idx    <= '0;
    end else if (state == S_SCAN && !issue_done) begin
      scan_idx   <= scan_idx + IDX_W'(1);
      issue_done <= (scan_idx == IDX_W'(TABLE_DEPTH - 1));
      chk_vld    <= 1'b1;
      chk_idx    <= scan_idx;
    end else begin
      scan_idx   <= '0;
      chk_vld    <= 1'b0;
    end
  end

  // Compare each returned slot against the request
  always_ff @(posedge clk) begin
    if (rst) begin
      best_hit  <= 1'b0;
      dflt_hit  <= 1'b0;
      exact_hit <= 1'b0;
      free_hit  <= 1'b0;
      best_len  <= '0;
    end else if (accept) begin
      best_hit  <= 1'b0;
      dflt_hit  <= 1'b0;
      exact_hit <= 1'b0;
      free_hit  <= 1'b0;
      best_len  <= '0;
    end else if (chk_vld) begin
      if (!entry_valid[chk_idx] && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= chk_idx;
      end
      if (chk_live) begin
        // longest match and default route for lookup
        if (rd_ent.len == 6'd0) begin
          dflt_hit <= 1'b1;
          dflt_ent <= rd_ent;
        end else if ((addr & len_mask(rd_ent.len)) == rd_ent.prefix &&
                     rd_ent.len > best_len) begin
          best_hit <= 1'b1;
          best_len <= rd_ent.len;
          best_ent <= rd_ent;
        end
        // exact prefix and length for add and delete
        if (!exact_hit && rd_ent.prefix == prefix && rd_ent.len == len) begin
          exact_hit  <= 1'b1;
          exact_idx  <= chk_idx;
          exact_same <= (rd_ent.direct == direct) && (rd_ent.gateway == gw) &&
                        (rd_ent.out_if == oif);
        end
      end
    end
  end

  // Resolve the outcome and the write-back
  always_comb begin
    res_status = ST_MISS;
    res_ent    = '0;
    ram_we     = 1'b0;
    ram_waddr  = exact_idx;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    case (req)
      REQ_LOOKUP: begin
        if (best_hit) begin
          res_status = ST_OK;
          res_ent    = best_ent;
        end else if (dflt_hit) begin
          res_status = ST_OK;
          res_ent    = dflt_ent;
        end
      end
      REQ_ADD: begin
        if (exact_hit && exact_same) begin
          res_status = ST_DUP;
        end else if (exact_hit) begin
          res_status = ST_OK;
          ram_we     = resolve_go;
          set_valid  = 1'b1;
        end else if (free_hit) begin
          res_status = ST_OK;
          ram_we     = resolve_go;
          ram_waddr  = free_idx;
          set_valid  = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_DEL: begin
        if (exact_hit) begin
          res_status = ST_OK;
          clr_valid  = 1'b1;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: res_status = ST_MISS;
    endcase
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (resolve_go) begin
      if (set_valid) begin
        entry_valid[ram_waddr] <= 1'b1;
      end
      if (clr_valid) begin
        entry_valid[exact_idx] <= 1'b0;
      end
    end
  end

  // Output register: load on resolve, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resolve_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_go) begin
      status          <= res_status;
      route_is_direct <= res_ent.direct;
      route_gateway   <= res_ent.gateway;
      route_out_if    <= res_ent.out_if;
      matched_len     <= res_ent.len;
    end
  end

  // A result appears only out of the resolve step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESOLVE))
    else $error("result loaded outside resolve");

  // The table is written only when a request resolves
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_RESOLVE) && resolve_go)
    else $error("table write outside resolve");

  // No compare is pending while idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !chk_vld)
    else $error("compare pending while idle");

  // An accepted request, taken only from idle, starts the scan with slot 0 pending
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && chk_vld && (chk_idx == '0))
    else $error("scan did not start after transfer");

endmodule

// ===== rtl/rte_ram.sv =====
module rte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
